// ----- hw/rtl/wcr_pkg.sv -----
// Shared types, widths and codes for the Wiegand card receiver.
package wcr_pkg;

	localparam int READERS     = 2;
	localparam int CARD_BITS   = 26;
	localparam int CNT_W       = $clog2(CARD_BITS);
	localparam int TICK_W      = 8;
	localparam int CMD_W       = 2;
	localparam int RDR_W       = 1;
	localparam int CFG_IDX_W   = 1;

	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = CMD_W + RDR_W;
	localparam int OUT_FIELD_W = CARD_BITS + 2 * READERS;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	localparam logic [TICK_W-1:0] GAP_RESET = TICK_W'(10);
	localparam logic [TICK_W-1:0] LED_RESET = TICK_W'(10);

	localparam logic [CFG_IDX_W-1:0] REG_BIT_GAP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LED_OFF = CFG_IDX_W'(1);

	localparam logic [CMD_W-1:0] CMD_SAMPLE   = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_BIT_TICK = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_LED_TICK = CMD_W'(2);

	typedef enum logic [1:0] {
		SYM_IDLE = 2'd0,
		SYM_ZERO = 2'd1,
		SYM_ONE  = 2'd2
	} sym_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [RDR_W-1:0] reader;
		logic             d0;
		logic             d1;
	} item_t;

	typedef struct packed {
		logic [TICK_W-1:0] gap_ld;
		logic [TICK_W-1:0] led_ld;
	} cfg_t;

	typedef struct packed {
		logic                 done;
		logic [CARD_BITS-1:0] code;
		logic                 busy;
		logic                 led;
	} chan_out_t;

endpackage

// ----- hw/rtl/wiegand_card_receiver_core.sv -----
// Top level of the Wiegand 26-bit card receiver with its item pipeline.
//
// Use: line samples and timer ticks enter on the s_ stream. s_tuser holds the
// command (sample, bit tick, LED tick) and the reader; s_tdata holds DATA0 and
// DATA1. Every accepted item gives exactly one item on the m_ stream: the card
// flag and reader in m_tuser, the card code and the busy and LED masks in
// m_tdata, the masks showing the state after that item.
// An accepted item is held in the input register; once the output register is free
// or being taken, the channel logic updates the reader state and loads the output
// register, and the item's result then shows on m_.
// One item is taken every cycle while m_tready keeps the output flowing;
// the rate is set by the single pass through the per-reader channel logic.
// When m_tready is low the output register holds its item, the input register
// fills, and s_tready drops until the result is taken.
// Reset clears the valid flags of both pipeline registers, sets the gap and LED delays to 10
// ticks, all readers idle with no bits held and all LEDs on.
// cfg_we writes register cfg_index (0 gap ticks, 1 LED off ticks) from
// cfg_data; write only while no item is in flight.
module wiegand_card_receiver_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [wcr_pkg::IN_TDATA_W-1:0]      s_tdata,  // data0, data1, zero fill
	input  logic [wcr_pkg::IN_TUSER_W-1:0]      s_tuser,  // command[1:0], reader
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wcr_pkg::OUT_TDATA_W-1:0]     m_tdata,  // card_code, busy_mask, led_mask, zero fill
	output logic [wcr_pkg::OUT_TUSER_W-1:0]     m_tuser,  // card_ready, card_reader
	input  logic                                cfg_we,
	input  logic [wcr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wcr_pkg::TICK_W-1:0]          cfg_data
);

	wcr_pkg::cfg_t                     cfg_q;
	wcr_pkg::item_t                    item_s1;
	logic                              v_s1, v_s2, adv;
	wcr_pkg::chan_out_t                res [wcr_pkg::READERS];
	logic                              ready_c;
	logic [wcr_pkg::RDR_W-1:0]         rdr_c;
	logic [wcr_pkg::CARD_BITS-1:0]     code_c;
	logic [wcr_pkg::READERS-1:0]       busy_c, led_c;
	logic [wcr_pkg::OUT_TDATA_W-1:0]   tdata_s2;
	logic [wcr_pkg::OUT_TUSER_W-1:0]   tuser_s2;

	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_ld <= wcr_pkg::GAP_RESET;
			cfg_q.led_ld <= wcr_pkg::LED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wcr_pkg::REG_BIT_GAP: cfg_q.gap_ld <= cfg_data;
				wcr_pkg::REG_LED_OFF: cfg_q.led_ld <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cmd    <= s_tuser[wcr_pkg::CMD_W-1:0];
			item_s1.reader <= s_tuser[wcr_pkg::IN_TUSER_W-1:wcr_pkg::CMD_W];
			item_s1.d0     <= s_tdata[0];
			item_s1.d1     <= s_tdata[1];
		end
	end

	for (genvar r = 0; r < wcr_pkg::READERS; r++) begin : g_rdr
		wcr_channel u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.sel    (item_s1.reader == wcr_pkg::RDR_W'(r)),
			.item   (item_s1),
			.cfg    (cfg_q),
			.res    (res[r])
		);
	end

	always_comb begin
		ready_c = 1'b0;
		rdr_c   = '0;
		code_c  = '0;
		for (int r = 0; r < wcr_pkg::READERS; r++) begin
			ready_c   = ready_c | res[r].done;
			code_c    = code_c | res[r].code;
			busy_c[r] = res[r].busy;
			led_c[r]  = res[r].led;
			if (res[r].done) begin
				rdr_c = wcr_pkg::RDR_W'(r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || m_tready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tdata_s2 <= {{(wcr_pkg::OUT_TDATA_W - wcr_pkg::OUT_FIELD_W){1'b0}},
				led_c, busy_c, code_c};
			tuser_s2 <= {rdr_c, ready_c};
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = tdata_s2;
	assign m_tuser  = tuser_s2;

endmodule

// ----- hw/rtl/wcr_channel.sv -----
// Per-reader frame state: bit assembly, gap timer and LED delay.
module wcr_channel (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              sel,
	input  wcr_pkg::item_t    item,
	input  wcr_pkg::cfg_t     cfg,
	output wcr_pkg::chan_out_t res
);

	wcr_pkg::sym_t                  sym_q, sym_n, sym_new;
	logic [wcr_pkg::CNT_W-1:0]      cnt_q, cnt_n;
	logic [wcr_pkg::CNT_W:0]        cnt_inc;
	logic [wcr_pkg::CARD_BITS-1:0]  shift_q, shift_n;
	logic [wcr_pkg::TICK_W-1:0]     gap_q, gap_n;
	logic [wcr_pkg::TICK_W-1:0]     ledt_q, ledt_n;
	logic                           busy_q, busy_n;
	logic                           led_q, led_n;
	logic                           done;

	always_comb begin
		sym_n   = sym_q;
		cnt_n   = cnt_q;
		shift_n = shift_q;
		gap_n   = gap_q;
		ledt_n  = ledt_q;
		busy_n  = busy_q;
		led_n   = led_q;
		done    = 1'b0;
		sym_new = item.d0 ? wcr_pkg::SYM_ZERO : wcr_pkg::SYM_ONE;
		cnt_inc = {1'b0, cnt_q} + {{wcr_pkg::CNT_W{1'b0}}, 1'b1};
		case (item.cmd)
			wcr_pkg::CMD_SAMPLE: begin
				if (sel) begin
					if (item.d0 == item.d1) begin
						sym_n = wcr_pkg::SYM_IDLE;
					end else if (sym_q != sym_new) begin
						gap_n = cfg.gap_ld;
						shift_n[cnt_q] = item.d1;
						if (cnt_inc >= (wcr_pkg::CNT_W+1)'(wcr_pkg::CARD_BITS)) begin
							done   = 1'b1;
							busy_n = 1'b0;
							ledt_n = cfg.led_ld;
							cnt_n  = '0;
							sym_n  = wcr_pkg::SYM_IDLE;
						end else begin
							cnt_n  = cnt_inc[wcr_pkg::CNT_W-1:0];
							busy_n = 1'b1;
							sym_n  = sym_new;
						end
					end
				end
			end
			wcr_pkg::CMD_BIT_TICK: begin
				if (gap_q == '0) begin
					cnt_n  = '0;
					sym_n  = wcr_pkg::SYM_IDLE;
					busy_n = 1'b0;
				end else begin
					gap_n = gap_q - 1'b1;
				end
			end
			wcr_pkg::CMD_LED_TICK: begin
				if (ledt_q == '0) begin
					led_n = 1'b1;
				end else begin
					led_n  = 1'b0;
					ledt_n = ledt_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q   <= wcr_pkg::SYM_IDLE;
			cnt_q   <= '0;
			shift_q <= '0;
			gap_q   <= '0;
			ledt_q  <= '0;
			busy_q  <= 1'b0;
			led_q   <= 1'b1;
		end else if (en) begin
			sym_q   <= sym_n;
			cnt_q   <= cnt_n;
			shift_q <= shift_n;
			gap_q   <= gap_n;
			ledt_q  <= ledt_n;
			busy_q  <= busy_n;
			led_q   <= led_n;
		end
	end

	assign res.done = done;
	assign res.code = done ? shift_n : '0;
	assign res.busy = busy_n;
	assign res.led  = led_n;

endmodule

// ----- hw/rtl/wcr_checker.sv -----
// Port-level checks for the Wiegand card receiver and their bind.
module wcr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [wcr_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [wcr_pkg::OUT_TUSER_W-1:0] m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_card_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(!m_tuser[1] && !m_tdata[wcr_pkg::CARD_BITS]) ||
			(m_tuser[1] && !m_tdata[wcr_pkg::CARD_BITS+1]))
		else $error("completed reader still busy");

	a_no_card_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |->
			m_tdata[wcr_pkg::CARD_BITS-1:0] == '0 && !m_tuser[1])
		else $error("card fields set without a card");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && $past(m_tvalid && !m_tready) && $past(s_tvalid && s_tready)
			|-> !s_tready)
		else $error("input taken with both registers full");

endmodule

bind wiegand_card_receiver_core wcr_checker u_wcr_checker (.*);

// ----- verif/tb_wiegand_card_receiver_core.sv -----
// Testbench for the Wiegand card receiver core: samples and ticks checked against a predictor.
`timescale 1ns / 100ps

module tb_wiegand_card_receiver_core;
	import wcr_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = CMD_W'(3);

	typedef struct packed {
		logic                 ready;
		logic                 rdr;
		logic [CARD_BITS-1:0] code;
		logic [READERS-1:0]   busy;
		logic [READERS-1:0]   led;
	} card_status_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [TICK_W-1:0]      cfg_data = '0;

	wiegand_card_receiver_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	item_t        sample_queue[$];
	item_t        lane0[$];
	item_t        lane1[$];
	card_status_t status_queue[$];
	int           errors = 0;

	logic [TICK_W-1:0]    gap_load;
	logic [TICK_W-1:0]    led_load;
	sym_t                 held_sym [READERS];
	logic [CNT_W-1:0]     bit_cnt  [READERS];
	logic [CARD_BITS-1:0] shift_reg[READERS];
	logic [TICK_W-1:0]    gap_cnt  [READERS];
	logic [TICK_W-1:0]    led_cnt  [READERS];
	logic                 busy_r   [READERS];
	logic                 led_r    [READERS];

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic item_t mk(input logic [CMD_W-1:0] cmd, input logic rdr,
		input logic d0, input logic d1);
		item_t it;
		it.cmd = cmd;
		it.reader = rdr;
		it.d0 = d0;
		it.d1 = d1;
		return it;
	endfunction

	function automatic item_t any_item();
		return mk(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	task automatic clear_readers();
		gap_load = GAP_RESET;
		led_load = LED_RESET;
		for (int r = 0; r < READERS; r++) begin
			held_sym[r] = SYM_IDLE;
			bit_cnt[r] = '0;
			shift_reg[r] = '0;
			gap_cnt[r] = '0;
			busy_r[r] = 1'b0;
			led_cnt[r] = '0;
			led_r[r] = 1'b1;
		end
	endtask

	task automatic step_readers(input item_t it);
		card_status_t want;
		sym_t s;
		int r;
		want = '0;
		r = int'(it.reader);
		case (it.cmd)
			CMD_SAMPLE: begin
				if (r < READERS) begin
					if (it.d0 == it.d1) begin
						held_sym[r] = SYM_IDLE;
					end else begin
						s = it.d0 ? SYM_ZERO : SYM_ONE;
						if (held_sym[r] != s) begin
							gap_cnt[r] = gap_load;
							held_sym[r] = s;
							shift_reg[r][bit_cnt[r]] = (s == SYM_ONE);
							bit_cnt[r] = bit_cnt[r] + 1'b1;
							busy_r[r] = 1'b1;
							if (bit_cnt[r] >= CARD_BITS) begin
								busy_r[r] = 1'b0;
								led_cnt[r] = led_load;
								bit_cnt[r] = '0;
								held_sym[r] = SYM_IDLE;
								want.ready = 1'b1;
								want.rdr = it.reader;
								want.code = shift_reg[r];
							end
						end
					end
				end
			end
			CMD_BIT_TICK: begin
				for (int i = 0; i < READERS; i++) begin
					if (gap_cnt[i] == 0) begin
						bit_cnt[i] = '0;
						held_sym[i] = SYM_IDLE;
						busy_r[i] = 1'b0;
					end else begin
						gap_cnt[i] = gap_cnt[i] - 1'b1;
					end
				end
			end
			CMD_LED_TICK: begin
				for (int i = 0; i < READERS; i++) begin
					if (led_cnt[i] == 0) begin
						led_r[i] = 1'b1;
					end else begin
						led_r[i] = 1'b0;
						led_cnt[i] = led_cnt[i] - 1'b1;
					end
				end
			end
			default: ;
		endcase
		for (int i = 0; i < READERS; i++) begin
			want.busy[i] = busy_r[i];
			want.led[i] = led_r[i];
		end
		status_queue.push_back(want);
	endtask

	int          gap_left = 0;
	int          burst_left = 8;
	item_t       cur_item;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				step_readers(cur_item);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					cur_item = sample_queue.pop_front();
					s_tuser <= {cur_item.reader, cur_item.cmd};
					s_tdata <= {{(IN_TDATA_W-2){1'b0}}, cur_item.d1, cur_item.d0};
					s_tvalid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	int           rdy_cycle = 0;
	int           rdy_mode = 0;
	card_status_t got;
	card_status_t want_st;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.ready = m_tuser[0];
				got.rdr = m_tuser[1];
				got.code = m_tdata[CARD_BITS-1:0];
				got.busy = m_tdata[CARD_BITS +: READERS];
				got.led = m_tdata[CARD_BITS+READERS +: READERS];
				if (status_queue.size() == 0) begin
					if (errors < 10)
						$display("unexpected item: ready=%0d reader=%0d code=%h busy=%b led=%b",
							got.ready, got.rdr, got.code, got.busy, got.led);
					errors++;
				end else begin
					want_st = status_queue.pop_front();
					if (got !== want_st) begin
						if (errors < 10) begin
							$display("mismatch: exp ready=%0d reader=%0d code=%h busy=%b led=%b",
								want_st.ready, want_st.rdr, want_st.code, want_st.busy,
								want_st.led);
							$display("          got ready=%0d reader=%0d code=%h busy=%b led=%b",
								got.ready, got.rdr, got.code, got.busy, got.led);
						end
						errors++;
					end
				end
			end
			rdy_cycle++;
			if (rdy_cycle % 64 == 0)
				rdy_mode = $urandom_range(0, 3);
			case (rdy_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rdy_cycle % 4 == 0);
				default: m_tready <= (rdy_cycle % 16 < 10);
			endcase
		end
	end

	task automatic wait_drained();
		while (sample_queue.size() > 0 || s_tvalid || status_queue.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input logic [TICK_W-1:0] gap_v, input logic [TICK_W-1:0] led_v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_BIT_GAP;
		cfg_data <= gap_v;
		@(posedge clk);
		cfg_index <= REG_LED_OFF;
		cfg_data <= led_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_load = gap_v;
		led_load = led_v;
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [CARD_BITS-1:0] pick_code();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CARD_BITS'($urandom);
		endcase
	endfunction

	task automatic build_frame(input logic rdr, input logic [CARD_BITS-1:0] code,
		input int nbits);
		sym_t prev;
		sym_t s;
		item_t it;
		prev = SYM_IDLE;
		for (int i = 0; i < nbits; i++) begin
			s = code[i] ? SYM_ONE : SYM_ZERO;
			it = mk(CMD_SAMPLE, rdr, ~code[i], code[i]);
			if (s == prev || $urandom_range(0, 3) == 0) begin
				if (rdr) lane1.push_back(mk(CMD_SAMPLE, rdr, 1'($urandom_range(0, 1)), 1'b0));
				else lane0.push_back(mk(CMD_SAMPLE, rdr, 1'($urandom_range(0, 1)), 1'b0));
				if (rdr) lane1[$].d1 = lane1[$].d0;
				else lane0[$].d1 = lane0[$].d0;
			end
			if (rdr) lane1.push_back(it);
			else lane0.push_back(it);
			if ($urandom_range(0, 3) == 0) begin
				if (rdr) lane1.push_back(it);
				else lane0.push_back(it);
			end
			prev = s;
		end
		it = mk(CMD_SAMPLE, rdr, 1'b0, 1'b0);
		if (rdr) lane1.push_back(it);
		else lane0.push_back(it);
	endtask

	task automatic merge_lanes(input int tick_odds);
		while (lane0.size() + lane1.size() > 0) begin
			if ($urandom_range(0, tick_odds - 1) == 0)
				sample_queue.push_back(mk(CMD_BIT_TICK, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			if ($urandom_range(0, 9) == 0)
				sample_queue.push_back(mk(CMD_LED_TICK, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			if ($urandom_range(0, 29) == 0)
				sample_queue.push_back(any_item());
			if (lane1.size() == 0 || (lane0.size() > 0 && $urandom_range(0, 1) == 1))
				sample_queue.push_back(lane0.pop_front());
			else
				sample_queue.push_back(lane1.pop_front());
		end
	endtask

	task automatic drop_partials();
		for (int i = 0; i <= int'(gap_load); i++)
			sample_queue.push_back(mk(CMD_BIT_TICK, 1'($urandom_range(0, 1)), 1'b0, 1'b0));
	endtask

	task automatic fill_phase(input int budget);
		int sel;
		int n;
		logic rdr;
		while (sample_queue.size() < budget) begin
			sel = $urandom_range(0, 99);
			rdr = 1'($urandom_range(0, 1));
			if (sel < 70) begin
				if (gap_load <= 20)
					drop_partials();
				build_frame(rdr, pick_code(), CARD_BITS);
				if ($urandom_range(0, 4) < 2)
					build_frame(~rdr, pick_code(), CARD_BITS);
				merge_lanes(gap_load < 4 ? 64 : 16);
			end else if (sel < 85 && gap_load <= 20) begin
				build_frame(rdr, pick_code(), $urandom_range(1, CARD_BITS - 1));
				merge_lanes(64);
				drop_partials();
			end else begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					sample_queue.push_back(any_item());
			end
		end
	endtask

	initial begin
		clear_readers();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		sample_queue.push_back(mk(CMD_SPARE, 1'b0, 1'b0, 1'b0));
		sample_queue.push_back(mk(CMD_SAMPLE, 1'b0, 1'b0, 1'b0));
		sample_queue.push_back(mk(CMD_SAMPLE, 1'b1, 1'b1, 1'b1));
		sample_queue.push_back(mk(CMD_BIT_TICK, 1'b1, 1'b1, 1'b0));
		sample_queue.push_back(mk(CMD_LED_TICK, 1'b0, 1'b0, 1'b1));
		sample_queue.push_back(mk(CMD_SAMPLE, 1'b0, 1'b1, 1'b0));
		sample_queue.push_back(mk(CMD_SAMPLE, 1'b0, 1'b1, 1'b0));
		sample_queue.push_back(mk(CMD_SAMPLE, 1'b0, 1'b0, 1'b1));
		sample_queue.push_back(mk(CMD_SAMPLE, 1'b1, 1'b0, 1'b1));
		sample_queue.push_back(mk(CMD_SAMPLE, 1'b1, 1'b1, 1'b1));
		sample_queue.push_back(mk(CMD_SAMPLE, 1'b1, 1'b0, 1'b1));
		sample_queue.push_back(mk(CMD_SPARE, 1'b1, 1'b1, 1'b1));
		sample_queue.push_back(mk(CMD_LED_TICK, 1'b1, 1'b1, 1'b1));
		for (int i = 0; i < 12; i++)
			sample_queue.push_back(mk(CMD_BIT_TICK, 1'(i), 1'b0, 1'b0));
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			case (p)
				1: write_regs(8'd0, 8'd0);
				2: write_regs(8'd255, 8'd255);
				3: write_regs(8'd3, 8'd5);
				4: write_regs(TICK_W'($urandom_range(1, 30)), TICK_W'($urandom_range(0, 40)));
				default: ;
			endcase
			fill_phase(50);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
